FILE: sv/dpbm_pkg.sv
package dpbm_pkg;

    localparam int MAX_SLOTS_DEFAULT = 16;
    localparam int DPB_SIZE_W        = 5;
    localparam int POC_W             = 16;
    localparam int BUF_W             = 16;
    localparam int SEQ_W             = 16;
    localparam int KEY_W             = SEQ_W + POC_W;
    localparam int OUT_SLOT_W        = 4;
    localparam logic [DPB_SIZE_W-1:0] DPB_SIZE_RESET = 5'd16;

    localparam logic [1:0] FUNC_NEW     = 2'd0;
    localparam logic [1:0] FUNC_DONE    = 2'd1;
    localparam logic [1:0] FUNC_RECYCLE = 2'd2;
    localparam logic [1:0] FUNC_OUTPUT  = 2'd3;

    typedef struct packed {
        logic [1:0]       func;
        logic [3:0]       slot;
        logic             ref_pic;
        logic             seq_start;
        logic [POC_W-1:0] poc;
        logic [BUF_W-1:0] buffer_id;
        logic             all_occupied;
    } req_t;

    typedef struct packed {
        logic                  found;
        logic [OUT_SLOT_W-1:0] out_slot;
        logic [BUF_W-1:0]      out_buffer;
    } rsp_t;

    typedef struct packed {
        logic op_latch;
        logic min_init;
        logic scan_start;
        logic scan_step;
        logic scan_sel;
        logic alloc_commit;
        logic alloc_fail;
        logic sel_finish;
        logic do_done;
        logic do_recycle;
        logic out_load;
    } dpbm_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       idx_end;
        logic       idx_unused;
        logic       scan_done;
        logic       out_free;
    } dpbm_status_t;

endpackage

FILE: sv/decoded_picture_buffer_manager_unit.sv
// Picture slot table for a video decoder: one operation word in (new picture,
// picture done, recycle, next output), exactly one result word out. The block
// takes one operation at a time. New picture scans the slots from index 0 for
// the first unused slot below n, n being dpb_size clamped to MAX_SLOTS; next
// output makes two passes over the slot keys at one read per cycle from the
// key memory, first for the minimum key and then for the first eligible slot
// holding it. A finished result sits in an output register, so the next
// operation is accepted while it waits; that operation holds in its last
// cycle until the waiting word is taken. The user must write dpb_size only
// while the block is idle; the block itself does not enforce this.
module decoded_picture_buffer_manager_unit
#(
    parameter int MAX_SLOTS = dpbm_pkg::MAX_SLOTS_DEFAULT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  dpbm_pkg::req_t                  req,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output dpbm_pkg::rsp_t                  rsp,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dpbm_pkg::DPB_SIZE_W-1:0] cfg_data
);

    import dpbm_pkg::*;

    dpbm_cmd_t    cmd;
    dpbm_status_t status;

    dpbm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    dpbm_datapath #(.MAX_SLOTS(MAX_SLOTS)) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

FILE: sv/dpbm_ram.sv
module dpbm_ram
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/dpbm_datapath.sv
module dpbm_datapath
#(
    parameter int MAX_SLOTS = dpbm_pkg::MAX_SLOTS_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  dpbm_pkg::dpbm_cmd_t               cmd,
    output dpbm_pkg::dpbm_status_t            status,
    input  dpbm_pkg::req_t                    req,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dpbm_pkg::DPB_SIZE_W-1:0]   cfg_data,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output dpbm_pkg::rsp_t                    rsp
);

    import dpbm_pkg::*;

    localparam int SLOT_W = $clog2(MAX_SLOTS);
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

    localparam logic [1:0] ST_UNUSED = 2'd0;
    localparam logic [1:0] ST_INIT   = 2'd1;
    localparam logic [1:0] ST_REF    = 2'd2;
    localparam logic [1:0] ST_READY  = 2'd3;

    logic [1:0]            slot_state_reg [MAX_SLOTS];
    logic [1:0]            slot_state_next [MAX_SLOTS];
    logic                  is_ref_reg [MAX_SLOTS];
    logic                  is_ref_next [MAX_SLOTS];
    logic                  key_valid_reg [MAX_SLOTS];
    logic                  key_valid_next [MAX_SLOTS];
    logic                  fwd_valid_reg, fwd_valid_next;
    logic [SLOT_W-1:0]     fwd_reg, fwd_next;
    logic                  bwd_valid_reg, bwd_valid_next;
    logic [SLOT_W-1:0]     bwd_reg, bwd_next;
    logic [SEQ_W-1:0]      seq_reg, seq_next;
    logic [DPB_SIZE_W-1:0] dpb_size_reg, dpb_size_next;
    logic [CNT_W-1:0]      scan_idx_reg, scan_idx_next;
    logic                  pipe_valid_reg, pipe_valid_next;
    logic [SLOT_W-1:0]     pipe_idx_reg, pipe_idx_next;
    logic                  sel_found_reg, sel_found_next;
    logic [SLOT_W-1:0]     sel_idx_reg, sel_idx_next;
    logic                  out_valid_reg, out_valid_next;

    req_t                  op_reg, op_next;
    logic [KEY_W-1:0]      min_key_reg, min_key_next;
    logic                  res_found_reg, res_found_next;
    logic [OUT_SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic [BUF_W-1:0]      res_buffer_reg, res_buffer_next;
    logic                  res_from_ram_reg, res_from_ram_next;
    rsp_t                  out_word_reg, out_word_next;

    logic [CNT_W-1:0]      active_cnt;
    logic [SLOT_W-1:0]     scan_addr;
    logic                  idx_end;
    logic [SLOT_W+3:0]     slot_ext;
    logic [SLOT_W-1:0]     slot_idx;
    logic                  slot_ok;
    logic                  key_rd_en;
    logic [KEY_W-1:0]      key_rd_data;
    logic [BUF_W-1:0]      buf_rd_data;
    logic                  buf_rd_en;
    logic [KEY_W-1:0]      pipe_key;
    logic                  pipe_occupied;
    logic                  pipe_eligible;
    logic [SEQ_W-1:0]      seq_bumped;
    logic [KEY_W-1:0]      new_key;

    function automatic logic [OUT_SLOT_W-1:0] slot_to_out(input logic [SLOT_W-1:0] idx);
        logic [SLOT_W+OUT_SLOT_W-1:0] ext;
        ext = {{OUT_SLOT_W{1'b0}}, idx};
        return ext[OUT_SLOT_W-1:0];
    endfunction

    assign active_cnt = (int'(dpb_size_reg) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS)
                                                         : CNT_W'(dpb_size_reg);
    assign scan_addr  = scan_idx_reg[SLOT_W-1:0];
    assign idx_end    = (scan_idx_reg >= active_cnt);
    assign slot_ext   = {{SLOT_W{1'b0}}, op_reg.slot};
    assign slot_idx   = slot_ext[SLOT_W-1:0];
    assign slot_ok    = (int'(op_reg.slot) < MAX_SLOTS);

    assign key_rd_en  = cmd.scan_step && !idx_end;
    assign buf_rd_en  = cmd.sel_finish && sel_found_reg;
    assign seq_bumped = op_reg.seq_start ? seq_reg + 1'b1 : seq_reg;
    assign new_key    = {seq_bumped, op_reg.poc};

    assign pipe_key      = key_valid_reg[pipe_idx_reg] ? key_rd_data : '0;
    assign pipe_occupied = (slot_state_reg[pipe_idx_reg] != ST_UNUSED);
    assign pipe_eligible = op_reg.all_occupied ? pipe_occupied
                                               : (slot_state_reg[pipe_idx_reg] == ST_READY);

    assign status.func       = op_reg.func;
    assign status.idx_end    = idx_end;
    assign status.idx_unused = (slot_state_reg[scan_addr] == ST_UNUSED);
    assign status.scan_done  = idx_end && !pipe_valid_reg;
    assign status.out_free   = !out_valid_reg || !rsp_stall;

    assign cfg_ready = 1'b1;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_word_reg;

    dpbm_ram #(.WIDTH(KEY_W), .DEPTH(MAX_SLOTS)) u_key_ram
    (
        .clk     (clk),
        .wr_en   (cmd.alloc_commit),
        .wr_addr (scan_addr),
        .wr_data (new_key),
        .rd_en   (key_rd_en),
        .rd_addr (scan_addr),
        .rd_data (key_rd_data)
    );

    dpbm_ram #(.WIDTH(BUF_W), .DEPTH(MAX_SLOTS)) u_buf_ram
    (
        .clk     (clk),
        .wr_en   (cmd.alloc_commit),
        .wr_addr (scan_addr),
        .wr_data (op_reg.buffer_id),
        .rd_en   (buf_rd_en),
        .rd_addr (sel_idx_reg),
        .rd_data (buf_rd_data)
    );

    always_comb
    begin
        slot_state_next = slot_state_reg;
        is_ref_next     = is_ref_reg;
        key_valid_next  = key_valid_reg;
        fwd_valid_next  = fwd_valid_reg;
        fwd_next        = fwd_reg;
        bwd_valid_next  = bwd_valid_reg;
        bwd_next        = bwd_reg;
        seq_next        = seq_reg;
        dpb_size_next   = dpb_size_reg;

        if (cfg_valid)
        begin
            dpb_size_next = cfg_data;
        end

        if (cmd.alloc_commit)
        begin
            seq_next                   = seq_bumped;
            slot_state_next[scan_addr] = ST_INIT;
            is_ref_next[scan_addr]     = op_reg.ref_pic;
            key_valid_next[scan_addr]  = 1'b1;
        end

        if (cmd.do_done && slot_ok)
        begin
            if (is_ref_reg[slot_idx])
            begin
                slot_state_next[slot_idx] = ST_REF;
                if (bwd_valid_reg)
                begin
                    slot_state_next[bwd_reg] = ST_READY;
                end
                bwd_valid_next = fwd_valid_reg;
                bwd_next       = fwd_reg;
                fwd_valid_next = 1'b1;
                fwd_next       = slot_idx;
            end
            else
            begin
                slot_state_next[slot_idx] = ST_READY;
            end
        end

        if (cmd.do_recycle && slot_ok)
        begin
            if (fwd_valid_reg && (fwd_reg == slot_idx))
            begin
                fwd_valid_next = 1'b0;
            end
            if (bwd_valid_reg && (bwd_reg == slot_idx))
            begin
                bwd_valid_next = 1'b0;
            end
            slot_state_next[slot_idx] = ST_UNUSED;
            is_ref_next[slot_idx]     = 1'b0;
            key_valid_next[slot_idx]  = 1'b0;
        end
    end

    always_comb
    begin
        scan_idx_next     = scan_idx_reg;
        pipe_valid_next   = key_rd_en;
        pipe_idx_next     = scan_addr;
        sel_found_next    = sel_found_reg;
        sel_idx_next      = sel_idx_reg;
        min_key_next      = min_key_reg;
        op_next           = op_reg;
        res_found_next    = res_found_reg;
        res_slot_next     = res_slot_reg;
        res_buffer_next   = res_buffer_reg;
        res_from_ram_next = res_from_ram_reg;
        out_valid_next    = out_valid_reg;
        out_word_next     = out_word_reg;

        if (cmd.op_latch)
        begin
            op_next           = req;
            res_found_next    = 1'b1;
            res_slot_next     = '0;
            res_buffer_next   = '0;
            res_from_ram_next = 1'b0;
        end

        if (cmd.scan_start)
        begin
            scan_idx_next = '0;
        end
        else if (key_rd_en)
        begin
            scan_idx_next = scan_idx_reg + 1'b1;
        end

        if (cmd.min_init)
        begin
            min_key_next   = '1;
            sel_found_next = 1'b0;
        end
        else if (pipe_valid_reg)
        begin
            if (!cmd.scan_sel)
            begin
                if (pipe_occupied && (pipe_key < min_key_reg))
                begin
                    min_key_next = pipe_key;
                end
            end
            else if (!sel_found_reg && pipe_eligible && (pipe_key == min_key_reg))
            begin
                sel_found_next = 1'b1;
                sel_idx_next   = pipe_idx_reg;
            end
        end

        if (cmd.alloc_commit)
        begin
            res_found_next  = 1'b1;
            res_slot_next   = slot_to_out(scan_addr);
            res_buffer_next = op_reg.buffer_id;
        end

        if (cmd.alloc_fail)
        begin
            res_found_next = 1'b0;
        end

        if (cmd.sel_finish)
        begin
            res_found_next    = sel_found_reg;
            res_slot_next     = sel_found_reg ? slot_to_out(sel_idx_reg) : '0;
            res_buffer_next   = '0;
            res_from_ram_next = sel_found_reg;
        end

        if (cmd.out_load)
        begin
            out_valid_next            = 1'b1;
            out_word_next.found       = res_found_reg;
            out_word_next.out_slot    = res_slot_reg;
            out_word_next.out_buffer  = res_from_ram_reg ? buf_rd_data : res_buffer_reg;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_SLOTS; k++)
            begin
                slot_state_reg[k] <= ST_UNUSED;
                is_ref_reg[k]     <= 1'b0;
                key_valid_reg[k]  <= 1'b0;
            end
            fwd_valid_reg  <= 1'b0;
            fwd_reg        <= '0;
            bwd_valid_reg  <= 1'b0;
            bwd_reg        <= '0;
            seq_reg        <= '0;
            dpb_size_reg   <= DPB_SIZE_RESET;
            scan_idx_reg   <= '0;
            pipe_valid_reg <= 1'b0;
            pipe_idx_reg   <= '0;
            sel_found_reg  <= 1'b0;
            sel_idx_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            slot_state_reg <= slot_state_next;
            is_ref_reg     <= is_ref_next;
            key_valid_reg  <= key_valid_next;
            fwd_valid_reg  <= fwd_valid_next;
            fwd_reg        <= fwd_next;
            bwd_valid_reg  <= bwd_valid_next;
            bwd_reg        <= bwd_next;
            seq_reg        <= seq_next;
            dpb_size_reg   <= dpb_size_next;
            scan_idx_reg   <= scan_idx_next;
            pipe_valid_reg <= pipe_valid_next;
            pipe_idx_reg   <= pipe_idx_next;
            sel_found_reg  <= sel_found_next;
            sel_idx_reg    <= sel_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg           <= op_next;
        min_key_reg      <= min_key_next;
        res_found_reg    <= res_found_next;
        res_slot_reg     <= res_slot_next;
        res_buffer_reg   <= res_buffer_next;
        res_from_ram_reg <= res_from_ram_next;
        out_word_reg     <= out_word_next;
    end

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !rsp_stall))
        else $error("result word loaded over an untaken word");

    a_alloc_unused: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc_commit |-> ((slot_state_reg[scan_addr] == ST_UNUSED) && !idx_end))
        else $error("allocation into an occupied or inactive slot");

    a_load_found: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (rsp_valid && (rsp.found == $past(res_found_reg))))
        else $error("result word lost after load");
`endif

endmodule

FILE: sv/dpbm_ctrl.sv
module dpbm_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  dpbm_pkg::dpbm_status_t status,
    output dpbm_pkg::dpbm_cmd_t    cmd
);

    import dpbm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ALLOC,
        S_MIN,
        S_SEL,
        S_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   stall_reg, stall_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op_latch = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (status.func)
                    FUNC_NEW:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_ALLOC;
                    end
                    FUNC_DONE:
                    begin
                        cmd.do_done = 1'b1;
                        state_next  = S_RESP;
                    end
                    FUNC_RECYCLE:
                    begin
                        cmd.do_recycle = 1'b1;
                        state_next     = S_RESP;
                    end
                    FUNC_OUTPUT:
                    begin
                        cmd.min_init   = 1'b1;
                        cmd.scan_start = 1'b1;
                        state_next     = S_MIN;
                    end
                endcase
            end
            S_ALLOC:
            begin
                if (status.idx_end)
                begin
                    cmd.alloc_fail = 1'b1;
                    state_next     = S_RESP;
                end
                else if (status.idx_unused)
                begin
                    cmd.alloc_commit = 1'b1;
                    state_next       = S_RESP;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_MIN:
            begin
                if (status.scan_done)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SEL;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_SEL:
            begin
                cmd.scan_sel = 1'b1;
                if (status.scan_done)
                begin
                    cmd.sel_finish = 1'b1;
                    state_next     = S_RESP;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_RESP:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign stall_next = (state_next != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= stall_next;
        end
    end

    assign req_stall = stall_reg;

endmodule

FILE: verif/decoded_picture_buffer_manager_unit_tb.sv
`timescale 1ns / 1ps

module decoded_picture_buffer_manager_unit_tb;

    import dpbm_pkg::*;

    localparam int SLOTS       = MAX_SLOTS_DEFAULT;
    localparam int CYCLE_LIMIT = 4_000_000;

    typedef enum logic [1:0] {PIC_FREE, PIC_INIT, PIC_REF, PIC_READY} pic_state_t;
    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    req_t                  req       = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_t                  rsp;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [DPB_SIZE_W-1:0] cfg_data  = '0;

    pic_state_t      pic_state [SLOTS];
    bit              pic_ref [SLOTS];
    bit [KEY_W-1:0]  pic_key [SLOTS];
    bit [BUF_W-1:0]  pic_buf [SLOTS];
    bit              buf_written [SLOTS];
    bit              fwd_ok;
    bit              bwd_ok;
    bit [3:0]        fwd_slot;
    bit [3:0]        bwd_slot;
    bit [SEQ_W-1:0]  seq_num;
    bit [DPB_SIZE_W-1:0] dpb_size_q;

    rsp_t     dpb_answers[$];
    rsp_t     want;
    int       errors     = 0;
    int       cycles     = 0;
    int       burst_left = 0;
    bit       full_rate  = 1'b0;
    rx_mode_t rx_mode    = RX_OPEN;
    int       rx_left    = 0;
    bit       stall_next;

    decoded_picture_buffer_manager_unit u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("decoded_picture_buffer_manager_unit_tb NOT OK");
            $finish;
        end
    end

    function automatic rsp_t run_dpb_op(input req_t r);
        rsp_t a;
        int   n;
        int   i;
        int   j;
        bit   hit;
        bit   ok;
        bit   eligible;
        a   = '0;
        hit = 1'b0;
        n   = (int'(dpb_size_q) > SLOTS) ? SLOTS : int'(dpb_size_q);
        case (r.func)
            FUNC_NEW:
            begin
                for (i = 0; i < n; i++)
                begin
                    if (!hit && pic_state[i] == PIC_FREE)
                    begin
                        hit = 1'b1;
                        if (r.seq_start)
                            seq_num = seq_num + 1'b1;
                        pic_state[i]   = PIC_INIT;
                        pic_ref[i]     = r.ref_pic;
                        pic_buf[i]     = r.buffer_id;
                        buf_written[i] = 1'b1;
                        pic_key[i]     = {seq_num, r.poc};
                        a.found        = 1'b1;
                        a.out_slot     = i[3:0];
                        a.out_buffer   = r.buffer_id;
                    end
                end
            end
            FUNC_DONE:
            begin
                a.found = 1'b1;
                if (pic_ref[r.slot])
                begin
                    pic_state[r.slot] = PIC_REF;
                    if (bwd_ok)
                        pic_state[bwd_slot] = PIC_READY;
                    bwd_ok   = fwd_ok;
                    bwd_slot = fwd_slot;
                    fwd_ok   = 1'b1;
                    fwd_slot = r.slot;
                end
                else
                    pic_state[r.slot] = PIC_READY;
            end
            FUNC_RECYCLE:
            begin
                a.found = 1'b1;
                if (fwd_ok && fwd_slot == r.slot)
                    fwd_ok = 1'b0;
                if (bwd_ok && bwd_slot == r.slot)
                    bwd_ok = 1'b0;
                pic_state[r.slot] = PIC_FREE;
                pic_ref[r.slot]   = 1'b0;
                pic_key[r.slot]   = '0;
            end
            default:
            begin
                for (i = 0; i < n; i++)
                begin
                    eligible = r.all_occupied ? (pic_state[i] != PIC_FREE)
                                              : (pic_state[i] == PIC_READY);
                    if (!hit && eligible)
                    begin
                        ok = 1'b1;
                        for (j = 0; j < n; j++)
                            if (j != i && pic_state[j] != PIC_FREE && pic_key[j] < pic_key[i])
                                ok = 1'b0;
                        if (ok)
                        begin
                            hit          = 1'b1;
                            a.found      = 1'b1;
                            a.out_slot   = i[3:0];
                            a.out_buffer = pic_buf[i];
                        end
                    end
                end
            end
        endcase
        return a;
    endfunction

    function automatic req_t op_word(input logic [1:0] func, input int slot, input int is_ref,
                                     input int new_seq, input int poc, input int buf_id,
                                     input int flush);
        req_t r;
        r.func         = func;
        r.slot         = slot[3:0];
        r.ref_pic      = is_ref[0];
        r.seq_start    = new_seq[0];
        r.poc          = poc[POC_W-1:0];
        r.buffer_id    = buf_id[BUF_W-1:0];
        r.all_occupied = flush[0];
        return r;
    endfunction

    function automatic req_t random_op();
        req_t r;
        int   roll;
        int   i;
        int   init_c[$];
        int   ready_c[$];
        int   busy_c[$];
        int   wr_c[$];
        for (i = 0; i < SLOTS; i++)
        begin
            if (pic_state[i] == PIC_INIT)
                init_c.push_back(i);
            if (pic_state[i] == PIC_READY)
                ready_c.push_back(i);
            if (pic_state[i] != PIC_FREE)
                busy_c.push_back(i);
            if (buf_written[i])
                wr_c.push_back(i);
        end
        r.func         = FUNC_NEW;
        r.slot         = 4'($urandom_range(0, 15));
        r.ref_pic      = 1'($urandom_range(0, 1));
        r.seq_start    = ($urandom_range(0, 9) == 0);
        r.poc          = POC_W'($urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom);
        r.buffer_id    = BUF_W'($urandom);
        r.all_occupied = ($urandom_range(0, 3) == 0);
        roll = $urandom_range(0, 99);
        if (roll < 30)
            r.func = FUNC_NEW;
        else if (roll < 55)
        begin
            if (init_c.size() != 0 && $urandom_range(0, 4) != 0)
            begin
                r.func = FUNC_DONE;
                r.slot = 4'(init_c[$urandom_range(0, init_c.size() - 1)]);
            end
            else if (wr_c.size() != 0)
            begin
                r.func = FUNC_DONE;
                r.slot = 4'(wr_c[$urandom_range(0, wr_c.size() - 1)]);
            end
        end
        else if (roll < 75)
            r.func = FUNC_OUTPUT;
        else if (roll < 95)
        begin
            r.func = FUNC_RECYCLE;
            roll = $urandom_range(0, 9);
            if (ready_c.size() != 0 && roll < 7)
                r.slot = 4'(ready_c[$urandom_range(0, ready_c.size() - 1)]);
            else if (busy_c.size() != 0 && roll < 9)
                r.slot = 4'(busy_c[$urandom_range(0, busy_c.size() - 1)]);
        end
        else
        begin
            r.func = 2'($urandom_range(0, 3));
            // hold done to slots whose buffer id has been stored
            if (r.func == FUNC_DONE && !buf_written[r.slot])
            begin
                if (wr_c.size() == 0)
                    r.func = FUNC_NEW;
                else
                    r.slot = 4'(wr_c[$urandom_range(0, wr_c.size() - 1)]);
            end
        end
        return r;
    endfunction

    task automatic send_op(input req_t r);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = (full_rate || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        dpb_answers.push_back(run_dpb_op(r));
    endtask

    task automatic drain_results();
        req_valid  <= 1'b0;
        burst_left = 0;
        while (dpb_answers.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_dpb_size(input logic [DPB_SIZE_W-1:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        dpb_size_q = v;
    endtask

    task automatic flag_bad(input string what, input logic [31:0] exp_v,
                            input logic [31:0] act_v);
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (dpb_answers.size() == 0)
                flag_bad("unexpected result word", 32'h0, {11'h0, rsp});
            else
            begin
                want = dpb_answers.pop_front();
                if (rsp.found !== want.found)
                    flag_bad("found", 32'(want.found), 32'(rsp.found));
                if (rsp.out_slot !== want.out_slot)
                    flag_bad("out_slot", 32'(want.out_slot), 32'(rsp.out_slot));
                if (rsp.out_buffer !== want.out_buffer)
                    flag_bad("out_buffer", 32'(want.out_buffer), 32'(rsp.out_buffer));
            end
        end
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 160);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:  stall_next = 1'b0;
            RX_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
            RX_HEAVY: stall_next = ($urandom_range(0, 9) < 7);
            default:  stall_next = ((cycles % 6) < 3);
        endcase
        rsp_stall <= full_rate ? 1'b0 : stall_next;
    end

    task automatic test_empty_output();
        send_op(op_word(FUNC_OUTPUT, 0, 0, 0, 0, 0, 0));
        send_op(op_word(FUNC_OUTPUT, 15, 1, 1, 'hFFFF, 'hFFFF, 1));
    endtask

    task automatic test_zero_size();
        write_dpb_size(5'd0);
        send_op(op_word(FUNC_NEW, 0, 1, 1, 'h1234, 'hABCD, 0));
        send_op(op_word(FUNC_OUTPUT, 0, 0, 0, 0, 0, 1));
    endtask

    task automatic test_table_full();
        write_dpb_size(5'd2);
        send_op(op_word(FUNC_NEW, 15, 1, 1, 'hFFFF, 'hFFFF, 1));
        send_op(op_word(FUNC_NEW, 0, 0, 0, 0, 0, 0));
        send_op(op_word(FUNC_NEW, 3, 1, 1, 7, 7, 0));
        send_op(op_word(FUNC_OUTPUT, 0, 0, 0, 0, 0, 1));
    endtask

    task automatic test_reference_shift();
        send_op(op_word(FUNC_DONE, 1, 0, 0, 0, 0, 0));
        send_op(op_word(FUNC_DONE, 0, 0, 0, 0, 0, 0));
        send_op(op_word(FUNC_OUTPUT, 0, 0, 0, 0, 0, 0));
        send_op(op_word(FUNC_RECYCLE, 1, 0, 0, 0, 0, 0));
        write_dpb_size(5'd4);
        send_op(op_word(FUNC_NEW, 0, 1, 0, 3, 'h1111, 0));
        send_op(op_word(FUNC_DONE, 1, 0, 0, 0, 0, 0));
        send_op(op_word(FUNC_NEW, 0, 1, 0, 1, 'h2222, 0));
        send_op(op_word(FUNC_DONE, 2, 0, 0, 0, 0, 0));
        send_op(op_word(FUNC_OUTPUT, 0, 0, 0, 0, 0, 0));
        send_op(op_word(FUNC_OUTPUT, 0, 0, 0, 0, 0, 1));
        send_op(op_word(FUNC_DONE, 1, 0, 0, 0, 0, 0));
    endtask

    task automatic test_recycle_refs();
        send_op(op_word(FUNC_RECYCLE, 1, 0, 0, 0, 0, 0));
        send_op(op_word(FUNC_RECYCLE, 5, 0, 0, 0, 0, 0));
        send_op(op_word(FUNC_DONE, 1, 0, 0, 0, 0, 0));
        send_op(op_word(FUNC_OUTPUT, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_sequence_bump();
        int i;
        drain_results();
        full_rate = 1'b1;
        for (i = 0; i < SLOTS; i++)
            send_op(op_word(FUNC_RECYCLE, i, 0, 0, 0, 0, 0));
        write_dpb_size(5'd1);
        repeat (4)
        begin
            send_op(op_word(FUNC_NEW, $urandom, $urandom, 1, $urandom, $urandom, 0));
            send_op(op_word(FUNC_RECYCLE, 0, 0, 0, 0, 0, 0));
        end
        send_op(op_word(FUNC_NEW, 0, 0, 0, 5, 'h5A5A, 0));
        write_dpb_size(5'd2);
        send_op(op_word(FUNC_NEW, 0, 0, 1, 'h10, 'hA5A5, 0));
        send_op(op_word(FUNC_OUTPUT, 0, 0, 0, 0, 0, 1));
        send_op(op_word(FUNC_OUTPUT, 0, 0, 0, 0, 0, 0));
        drain_results();
        full_rate = 1'b0;
    endtask

    task automatic test_random_traffic(input int count, input logic [DPB_SIZE_W-1:0] size);
        write_dpb_size(size);
        repeat (count)
        begin
            send_op(random_op());
            if ($urandom_range(0, 59) == 0)
                drain_results();
        end
    endtask

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            pic_state[i]   = PIC_FREE;
            pic_ref[i]     = 1'b0;
            pic_key[i]     = '0;
            pic_buf[i]     = '0;
            buf_written[i] = 1'b0;
        end
        fwd_ok     = 1'b0;
        bwd_ok     = 1'b0;
        fwd_slot   = '0;
        bwd_slot   = '0;
        seq_num    = '0;
        dpb_size_q = DPB_SIZE_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_output();
        test_zero_size();
        test_table_full();
        test_reference_shift();
        test_recycle_refs();
        test_sequence_bump();
        test_random_traffic(70, 5'd31);
        test_random_traffic(70, 5'd4);
        test_random_traffic(50, 5'd1);
        test_random_traffic(70, 5'($urandom_range(0, 31)));
        test_random_traffic(90, 5'd16);
        drain_results();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("decoded_picture_buffer_manager_unit_tb OK");
        else
            $display("decoded_picture_buffer_manager_unit_tb NOT OK");
        $finish;
    end

endmodule
